// ===== src/gwml_pkg.sv =====
// ----------------------------------------------------------------------------
// gwml_pkg
// Shared types and constants for the glyph width measure and layout block:
// action codes, register indexes, table entry types and the write request.
// ----------------------------------------------------------------------------
package gwml_pkg;

    // Glyph grid and table geometry
    localparam int GRID_LOG2  = 4;
    localparam int IDX_BITS   = 2 * GRID_LOG2;
    localparam int GLYPHS     = 1 << IDX_BITS;
    localparam int INK_BITS   = 5;
    localparam int PIX_BITS   = 8;
    localparam int CODE_BITS  = 8;
    localparam int START_BITS = 16;
    localparam int PENX_BITS  = 16;

    // Register widths
    localparam int LOG2_BITS  = 3;
    localparam int PAD_BITS   = 2;
    localparam int SPACE_BITS = 4;
    localparam int CFG_BITS   = 4;
    localparam int CFG_IDX_BITS = 2;

    typedef logic [INK_BITS-1:0]     ink_t;
    typedef logic [IDX_BITS-1:0]     idx_t;
    typedef logic [1:0]              action_t;
    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

    // Action codes
    localparam action_t ACT_PIXEL = 2'd0;
    localparam action_t ACT_CHAR  = 2'd1;
    localparam action_t ACT_PEN   = 2'd2;

    // Register indexes
    localparam cfg_idx_t REG_CELL_W_LOG2 = 2'd0;
    localparam cfg_idx_t REG_CELL_H_LOG2 = 2'd1;
    localparam cfg_idx_t REG_PADDING     = 2'd2;
    localparam cfg_idx_t REG_SPACE_WIDTH = 2'd3;

    // Character code of the space glyph
    localparam logic [CODE_BITS-1:0] SPACE_CODE = 8'd32;

    // Decoded atlas pixel
    typedef struct packed {
        logic hit;   // nonzero alpha and inside the atlas
        idx_t idx;   // cell row in the upper nibble, cell column in the lower
        ink_t ink;   // column inside the cell plus one
    } pix_t;

    // Table write request
    typedef struct packed {
        logic en;
        idx_t idx;
        ink_t data;
    } wr_req_t;

endpackage

// ===== src/gwml_cell_decode.sv =====
// ----------------------------------------------------------------------------
// gwml_cell_decode
// Map an atlas pixel to its glyph cell and the ink width it implies.
// ----------------------------------------------------------------------------
module gwml_cell_decode #(
    parameter int MAX_CELL_WIDTH = 16
) (
    input  logic [gwml_pkg::LOG2_BITS-1:0] cell_width_log2,
    input  logic [gwml_pkg::LOG2_BITS-1:0] cell_height_log2,
    input  logic [gwml_pkg::PIX_BITS-1:0]  pixel_x,
    input  logic [gwml_pkg::PIX_BITS-1:0]  pixel_y,
    input  logic [gwml_pkg::PIX_BITS-1:0]  pixel_alpha,
    output gwml_pkg::pix_t                 pix
);
    import gwml_pkg::*;

    // Largest cell width log2 allowed by the cell width limit
    localparam int WL_LIMIT = $clog2(MAX_CELL_WIDTH + 1) - 1;
    localparam logic [LOG2_BITS-1:0] WL_MAX = LOG2_BITS'(WL_LIMIT < 4 ? WL_LIMIT : 4);
    localparam logic [LOG2_BITS-1:0] HL_MAX = LOG2_BITS'(4);

    logic [LOG2_BITS-1:0] wl;
    logic [LOG2_BITS-1:0] hl;
    logic [PIX_BITS-1:0]  ccol;
    logic [PIX_BITS-1:0]  crow;
    logic [PIX_BITS-1:0]  inner_mask;
    logic [PIX_BITS-1:0]  inner;

    // Clamp the cell size
    assign wl = (cell_width_log2 > WL_MAX) ? WL_MAX : cell_width_log2;
    assign hl = (cell_height_log2 > HL_MAX) ? HL_MAX : cell_height_log2;

    // Split the pixel position into cell and offset
    assign ccol       = pixel_x >> wl;
    assign crow       = pixel_y >> hl;
    assign inner_mask = ~(8'hFF << wl);
    assign inner      = pixel_x & inner_mask;

    always_comb
    begin
        pix.hit  = (pixel_alpha != '0) && (ccol[PIX_BITS-1:GRID_LOG2] == '0)
                   && (crow[PIX_BITS-1:GRID_LOG2] == '0);
        pix.idx  = {crow[GRID_LOG2-1:0], ccol[GRID_LOG2-1:0]};
        pix.ink  = INK_BITS'(inner) + INK_BITS'(1);
    end

endmodule

// ===== src/gwml_ink_table.sv =====
// ----------------------------------------------------------------------------
// gwml_ink_table
// Ink width table: synchronous memory with registered read, per-entry valid
// bits cleared at reset, and forwarding of a write that lands on the entry
// being read in the same cycle.
// ----------------------------------------------------------------------------
module gwml_ink_table (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  gwml_pkg::idx_t      rd_idx,
    input  gwml_pkg::wr_req_t   wr,
    output gwml_pkg::ink_t      rd_data
);
    import gwml_pkg::*;

    ink_t             mem [GLYPHS];
    ink_t             mem_q_reg;
    logic [GLYPHS-1:0] valid_reg;
    idx_t             rd_idx_reg;
    logic             fwd_hit_reg;
    ink_t             fwd_data_reg;

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_idx];
        end
    end

    // Valid bits and forwarding capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_idx_reg   <= '0;
            fwd_hit_reg  <= 1'b0;
            fwd_data_reg <= '0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_idx_reg   <= rd_idx;
                fwd_hit_reg  <= wr.en && (wr.idx == rd_idx);
                fwd_data_reg <= wr.data;
            end
        end
    end

    // Resolve the read: forwarded write, stored entry, or cleared entry
    assign rd_data = fwd_hit_reg          ? fwd_data_reg :
                     valid_reg[rd_idx_reg] ? mem_q_reg   : '0;

endmodule

// ===== src/glyph_width_measure_and_layout.sv =====
// ----------------------------------------------------------------------------
// glyph_width_measure_and_layout
// Measure glyph ink widths from atlas pixels and lay out text characters.
//
//   Channel  Direction  Payload
//   s_*      in         tuser: action; tdata: pixel_x, pixel_y, pixel_alpha,
//                       char_code, start_x
//   m_*      out        tdata: pen_x, glyph_width, atlas_col, atlas_row, draw
//   cfg_*    in         register index and write data, no read-back
//
// One item per cycle sustained unless the output stalls. An item reads the ink
// table when accepted and in the second stage modifies, writes back or emits
// into the output register; a write to the entry read in the same cycle is
// forwarded. Reset clears the table through per-entry valid bits, so items are
// taken at once after reset. A stalled output holds a character in the second
// stage and stops input transfers; pixel and pen items leave the second stage
// without waiting.
// ----------------------------------------------------------------------------
module glyph_width_measure_and_layout #(
    parameter int MAX_CELL_WIDTH = 16,
    parameter int PEN_BITS       = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [47:0]                        s_tdata,  // pixel_x, pixel_y, pixel_alpha,
                                                         // char_code, start_x
    input  gwml_pkg::action_t                  s_tuser,  // action
    // Output stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,  // pen_x, glyph_width, atlas_col,
                                                         // atlas_row, draw, zero fill
    // Configuration port
    input  logic                               cfg_we,
    input  gwml_pkg::cfg_idx_t                 cfg_index,
    input  logic [gwml_pkg::CFG_BITS-1:0]      cfg_data
);
    import gwml_pkg::*;

    // Configuration registers
    logic [LOG2_BITS-1:0]  cell_w_log2_reg;
    logic [LOG2_BITS-1:0]  cell_h_log2_reg;
    logic [PAD_BITS-1:0]   padding_reg;
    logic [SPACE_BITS-1:0] space_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_w_log2_reg <= LOG2_BITS'(3);
            cell_h_log2_reg <= LOG2_BITS'(3);
            padding_reg     <= PAD_BITS'(1);
            space_width_reg <= SPACE_BITS'(3);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CELL_W_LOG2: cell_w_log2_reg <= cfg_data[LOG2_BITS-1:0];
                REG_CELL_H_LOG2: cell_h_log2_reg <= cfg_data[LOG2_BITS-1:0];
                REG_PADDING:     padding_reg     <= cfg_data[PAD_BITS-1:0];
                REG_SPACE_WIDTH: space_width_reg <= cfg_data[SPACE_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // Unpack input fields
    logic [PIX_BITS-1:0]   in_pixel_x;
    logic [PIX_BITS-1:0]   in_pixel_y;
    logic [PIX_BITS-1:0]   in_pixel_alpha;
    logic [CODE_BITS-1:0]  in_char_code;
    logic [START_BITS-1:0] in_start_x;

    assign in_pixel_x     = s_tdata[7:0];
    assign in_pixel_y     = s_tdata[15:8];
    assign in_pixel_alpha = s_tdata[23:16];
    assign in_char_code   = s_tdata[31:24];
    assign in_start_x     = s_tdata[47:32];

    // Decode the pixel cell
    pix_t in_pix;

    gwml_cell_decode #(
        .MAX_CELL_WIDTH (MAX_CELL_WIDTH)
    ) u_decode (
        .cell_width_log2  (cell_w_log2_reg),
        .cell_height_log2 (cell_h_log2_reg),
        .pixel_x          (in_pixel_x),
        .pixel_y          (in_pixel_y),
        .pixel_alpha      (in_pixel_alpha),
        .pix              (in_pix)
    );

    // Second stage registers
    logic                  s1_valid_reg;
    action_t               s1_action_reg;
    pix_t                  s1_pix_reg;
    logic [CODE_BITS-1:0]  s1_code_reg;
    logic [START_BITS-1:0] s1_start_reg;
    logic [PEN_BITS-1:0]   pen_reg;
    logic                  out_valid_reg;
    logic [31:0]           out_data_reg;

    logic    in_xfer;
    logic    s1_go;
    idx_t    rd_idx;
    ink_t    ink;
    wr_req_t wr;

    // Advance the second stage unless a character waits on a full output
    assign s1_go    = s1_valid_reg && ((s1_action_reg != ACT_CHAR) || !out_valid_reg
                                       || m_tready);
    assign s_tready = !s1_valid_reg || s1_go;
    assign in_xfer  = s_tvalid && s_tready;
    assign rd_idx   = (s_tuser == ACT_PIXEL) ? in_pix.idx : idx_t'(in_char_code);

    gwml_ink_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_xfer),
        .rd_idx  (rd_idx),
        .wr      (wr),
        .rd_data (ink)
    );

    // Raise the stored ink width
    always_comb
    begin
        wr.en   = s1_valid_reg && (s1_action_reg == ACT_PIXEL) && s1_pix_reg.hit
                  && (s1_pix_reg.ink > ink);
        wr.idx  = s1_pix_reg.idx;
        wr.data = s1_pix_reg.ink;
    end

    // Glyph advance width and result fields
    ink_t                          glyph_w;
    logic [PEN_BITS+PENX_BITS-1:0] pen_wide;
    logic [PEN_BITS+START_BITS-1:0] start_wide;
    logic [31:0]                   result;

    assign glyph_w    = (s1_code_reg == SPACE_CODE)
                        ? INK_BITS'(space_width_reg) + INK_BITS'(padding_reg)
                        : ink + INK_BITS'(padding_reg);
    assign pen_wide   = {{PENX_BITS{1'b0}}, pen_reg};
    assign start_wide = {{PEN_BITS{1'b0}}, s1_start_reg};
    assign result     = {2'b00, (glyph_w != '0), s1_code_reg[7:4], s1_code_reg[3:0],
                         glyph_w, pen_wide[PENX_BITS-1:0]};

    // Pipeline, pen and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_action_reg <= ACT_PIXEL;
            pen_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                s1_valid_reg  <= 1'b1;
                s1_action_reg <= s_tuser;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s1_go)
            begin
                case (s1_action_reg)
                    ACT_CHAR:
                    begin
                        pen_reg       <= pen_reg + PEN_BITS'(glyph_w);
                        out_valid_reg <= 1'b1;
                    end
                    ACT_PEN:
                    begin
                        pen_reg <= start_wide[PEN_BITS-1:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_pix_reg   <= in_pix;
            s1_code_reg  <= in_char_code;
            s1_start_reg <= in_start_x;
        end
        if (s1_go && (s1_action_reg == ACT_CHAR))
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== sim/glyph_width_measure_and_layout_tb.sv =====
// ----------------------------------------------------------------------------
// glyph_width_measure_and_layout_tb
// Self-checking testbench for the glyph width measure and layout block.
// A directed table covers reset state, field extremes, every action code,
// out-of-atlas and zero-alpha pixels, the space glyph, oversized cells and
// pen wrap. Random phases with new register settings follow. Every accepted
// item runs through a local copy of the ink table and pen. Each result
// transfer is checked field by field against the oldest expected glyph.
// ----------------------------------------------------------------------------
module glyph_width_measure_and_layout_tb;

    import gwml_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 12;
    localparam int STALL_MAX     = 10;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int QUIET_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 1330;
    localparam int PHASES        = 9;
    localparam int MAX_CELL_W    = 16;

    // Action code that the block ignores
    localparam action_t ACT_NONE = 2'd3;

    typedef struct packed {
        logic [PENX_BITS-1:0] pen_x;
        logic [4:0]           width;
        logic [3:0]           col;
        logic [3:0]           row;
        logic                 draw;
    } glyph_t;

    typedef struct {
        glyph_t glyph;
        bit     pinned;
        glyph_t pin;
    } glyph_expect_t;

    typedef enum bit {STEP_CFG, STEP_ITEM} step_kind_t;

    typedef struct {
        step_kind_t           kind;
        cfg_idx_t             reg_idx;
        logic [CFG_BITS-1:0]  reg_val;
        action_t              act;
        logic [47:0]          data;
        bit                   pinned;
        glyph_t               want;
    } step_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [47:0]         s_tdata;
    action_t             s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [31:0]         m_tdata;
    logic                cfg_we;
    cfg_idx_t            cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    // Local copy of the block state and registers
    logic [INK_BITS-1:0]  ink_width [GLYPHS];
    logic [PENX_BITS-1:0] pen_pos;
    logic [2:0]           cw_log2;
    logic [2:0]           ch_log2;
    logic [1:0]           pad_cols;
    logic [3:0]           space_cols;

    glyph_expect_t pending_glyphs[$];
    int unsigned   mismatches = 0;
    int unsigned   quiet_cycles = 0;
    bit            burst;
    bit            pin_armed;
    glyph_t        pin_want;

    glyph_width_measure_and_layout dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Layout prediction
    // ------------------------------------------------------------------

    function automatic int unsigned eff_width_log2();
        int unsigned l;
        l = (cw_log2 > 3'd4) ? 4 : cw_log2;
        while (l > 0 && (1 << l) > MAX_CELL_W)
            l--;
        return l;
    endfunction

    function automatic int unsigned eff_height_log2();
        return (ch_log2 > 3'd4) ? 4 : ch_log2;
    endfunction

    function automatic logic [47:0] pack_item(input int unsigned x, input int unsigned y,
                                              input int unsigned alpha,
                                              input int unsigned code,
                                              input int unsigned start);
        return {start[15:0], code[7:0], alpha[7:0], y[7:0], x[7:0]};
    endfunction

    // Raise the ink width of the pixel's cell
    task automatic measure_pixel(input logic [47:0] d);
        int unsigned wl;
        int unsigned hl;
        int unsigned ccol;
        int unsigned crow;
        int unsigned inner;
        int unsigned idx;
        wl    = eff_width_log2();
        hl    = eff_height_log2();
        ccol  = d[7:0] >> wl;
        crow  = d[15:8] >> hl;
        inner = d[7:0] & ((1 << wl) - 1);
        idx   = crow * 16 + ccol;
        if (d[23:16] != 8'd0 && ccol < 16 && crow < 16 && inner + 1 > ink_width[idx])
            ink_width[idx] = INK_BITS'(inner + 1);
    endtask

    // Look up the advance width, build the quad and move the pen
    function automatic glyph_t lay_out_char(input logic [CODE_BITS-1:0] code);
        glyph_t g;
        logic [4:0] w;
        w = (code == SPACE_CODE) ? space_cols + pad_cols : ink_width[code] + pad_cols;
        g.pen_x = pen_pos;
        g.width = w;
        g.col   = code[3:0];
        g.row   = code[7:4];
        g.draw  = (w != 5'd0);
        pen_pos = pen_pos + w;
        return g;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic compare_glyph(input glyph_t got, input glyph_t want, input string src);
        if (got.pen_x !== want.pen_x)
            report_mismatch($sformatf("%s pen_x got %0d want %0d", src, got.pen_x, want.pen_x));
        if (got.width !== want.width)
            report_mismatch($sformatf("%s glyph_width got %0d want %0d", src, got.width,
                                      want.width));
        if (got.col !== want.col)
            report_mismatch($sformatf("%s atlas_col got %0d want %0d", src, got.col, want.col));
        if (got.row !== want.row)
            report_mismatch($sformatf("%s atlas_row got %0d want %0d", src, got.row, want.row));
        if (got.draw !== want.draw)
            report_mismatch($sformatf("%s draw got %0b want %0b", src, got.draw, want.draw));
    endtask

    // ------------------------------------------------------------------
    // Check output transfers, then track register writes and input transfers
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : glyph_scoreboard
        glyph_expect_t e;
        glyph_t        got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.pen_x = m_tdata[15:0];
                got.width = m_tdata[20:16];
                got.col   = m_tdata[24:21];
                got.row   = m_tdata[28:25];
                got.draw  = m_tdata[29];
                if (pending_glyphs.size() == 0)
                    report_mismatch("result transfer with no glyph expected");
                else
                begin
                    e = pending_glyphs.pop_front();
                    compare_glyph(got, e.glyph, "predicted");
                    if (e.pinned)
                        compare_glyph(got, e.pin, "table");
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CELL_W_LOG2: cw_log2    = cfg_data[2:0];
                    REG_CELL_H_LOG2: ch_log2    = cfg_data[2:0];
                    REG_PADDING:     pad_cols   = cfg_data[1:0];
                    REG_SPACE_WIDTH: space_cols = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    ACT_PIXEL: measure_pixel(s_tdata);
                    ACT_CHAR:
                    begin
                        e.glyph  = lay_out_char(s_tdata[31:24]);
                        e.pinned = pin_armed;
                        e.pin    = pin_want;
                        pending_glyphs.push_back(e);
                    end
                    ACT_PEN: pen_pos = s_tdata[47:32];
                    default: ;
                endcase
            end
        end
        else
        begin
            // Clear the local table and load the register reset values
            foreach (ink_width[i])
                ink_width[i] = '0;
            pen_pos    = '0;
            cw_log2    = 3'd3;
            ch_log2    = 3'd3;
            pad_cols   = 2'd1;
            space_cols = 4'd3;
        end
    end

    // Abort when no transfer of any kind happens for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Result side: stall a random number of cycles before each transfer
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = burst ? 0 : $urandom_range(0, STALL_MAX);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Idle a random gap, then hold the item until its transfer
    task automatic send_item(input action_t act, input logic [47:0] d);
        int unsigned gap;
        @(negedge clk);
        gap = burst ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = d;
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop valid and wait until every expected glyph has arrived
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_glyphs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_BITS-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Reset, minimum, maximum and oversized settings first, then random ones
    task automatic set_layout_regs(input int unsigned phase);
        case (phase)
            0:
            begin
                write_reg(REG_CELL_W_LOG2, 4'd3);
                write_reg(REG_CELL_H_LOG2, 4'd3);
                write_reg(REG_PADDING, 4'd1);
                write_reg(REG_SPACE_WIDTH, 4'd3);
            end
            1:
            begin
                write_reg(REG_CELL_W_LOG2, 4'd0);
                write_reg(REG_CELL_H_LOG2, 4'd0);
                write_reg(REG_PADDING, 4'd0);
                write_reg(REG_SPACE_WIDTH, 4'd0);
            end
            2:
            begin
                write_reg(REG_CELL_W_LOG2, 4'd4);
                write_reg(REG_CELL_H_LOG2, 4'd4);
                write_reg(REG_PADDING, 4'd3);
                write_reg(REG_SPACE_WIDTH, 4'd15);
            end
            3:
            begin
                write_reg(REG_CELL_W_LOG2, 4'd7);
                write_reg(REG_CELL_H_LOG2, 4'd5);
                write_reg(REG_PADDING, 4'd2);
                write_reg(REG_SPACE_WIDTH, 4'd9);
            end
            default:
            begin
                write_reg(REG_CELL_W_LOG2, CFG_BITS'($urandom_range(0, 7)));
                write_reg(REG_CELL_H_LOG2, CFG_BITS'($urandom_range(0, 7)));
                write_reg(REG_PADDING, CFG_BITS'($urandom_range(0, 3)));
                write_reg(REG_SPACE_WIDTH, CFG_BITS'($urandom_range(0, 15)));
            end
        endcase
    endtask

    function automatic step_t cfg_step(input cfg_idx_t idx, input logic [CFG_BITS-1:0] val);
        step_t s;
        s         = '{kind: STEP_CFG, default: '0};
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    function automatic step_t item_step(input action_t act, input int unsigned x,
                                        input int unsigned y, input int unsigned alpha,
                                        input int unsigned code, input int unsigned start);
        step_t s;
        s      = '{kind: STEP_ITEM, default: '0};
        s.act  = act;
        s.data = pack_item(x, y, alpha, code, start);
        return s;
    endfunction

    // Character row whose result is known by inspection
    function automatic step_t glyph_step(input int unsigned code, input int unsigned pen,
                                         input int unsigned w, input bit draw);
        step_t s;
        s        = item_step(ACT_CHAR, 0, 0, 0, code, 0);
        s.pinned = 1'b1;
        s.want   = '{pen[15:0], w[4:0], code[3:0], code[7:4], draw};
        return s;
    endfunction

    initial
    begin : stimulus
        step_t       directed[$];
        action_t     act;
        logic [47:0] d;
        int unsigned n;
        int unsigned pick;
        int unsigned x_span;
        int unsigned y_span;
        s_tvalid  = 1'b0;
        s_tuser   = ACT_PIXEL;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_CELL_W_LOG2;
        cfg_data  = '0;
        burst     = 1'b0;
        pin_armed = 1'b0;
        pin_want  = '0;

        // Hold reset once at the start
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset state, pen wrap, zero width, pixel corner cases, oversized cells
        directed.push_back(glyph_step(65, 16'h0000, 1, 1'b1));
        directed.push_back(glyph_step(SPACE_CODE, 16'h0001, 4, 1'b1));
        directed.push_back(item_step(ACT_PEN, 0, 0, 0, 0, 16'hFFFF));
        directed.push_back(glyph_step(255, 16'hFFFF, 1, 1'b1));
        directed.push_back(glyph_step(0, 16'h0000, 1, 1'b1));
        directed.push_back(cfg_step(REG_PADDING, 4'd0));
        directed.push_back(cfg_step(REG_SPACE_WIDTH, 4'd0));
        directed.push_back(glyph_step(200, 16'h0001, 0, 1'b0));
        directed.push_back(glyph_step(SPACE_CODE, 16'h0001, 0, 1'b0));
        directed.push_back(item_step(ACT_PIXEL, 255, 255, 255, 0, 0));
        directed.push_back(item_step(ACT_PIXEL, 0, 0, 0, 0, 0));
        directed.push_back(item_step(ACT_PIXEL, 7, 0, 1, 0, 0));
        directed.push_back(item_step(ACT_CHAR, 0, 0, 0, 0, 0));
        directed.push_back(cfg_step(REG_CELL_W_LOG2, 4'd7));
        directed.push_back(cfg_step(REG_CELL_H_LOG2, 4'd7));
        directed.push_back(item_step(ACT_PIXEL, 255, 255, 128, 0, 0));
        directed.push_back(item_step(ACT_CHAR, 0, 0, 0, 255, 0));
        directed.push_back(cfg_step(REG_PADDING, 4'd3));
        directed.push_back(cfg_step(REG_SPACE_WIDTH, 4'd15));
        directed.push_back(item_step(ACT_PIXEL, 5, 40, 1, 0, 0));
        directed.push_back(item_step(ACT_CHAR, 0, 0, 0, SPACE_CODE, 0));
        directed.push_back(item_step(ACT_CHAR, 0, 0, 0, 255, 0));
        directed.push_back(cfg_step(REG_CELL_W_LOG2, 4'd0));
        directed.push_back(cfg_step(REG_CELL_H_LOG2, 4'd0));
        directed.push_back(item_step(ACT_PIXEL, 3, 2, 9, 0, 0));
        directed.push_back(item_step(ACT_PIXEL, 16, 0, 9, 0, 0));
        directed.push_back(item_step(ACT_CHAR, 0, 0, 0, 35, 0));
        directed.push_back(item_step(ACT_PEN, 0, 0, 0, 0, 16'hFFF0));
        directed.push_back(item_step(ACT_CHAR, 0, 0, 0, 255, 0));
        directed.push_back(item_step(ACT_CHAR, 0, 0, 0, 255, 0));
        directed.push_back(item_step(ACT_NONE, 255, 255, 255, 65, 16'h1234));
        directed.push_back(item_step(ACT_CHAR, 0, 0, 0, 65, 0));

        // Walk the table; register writes only once the block is idle
        foreach (directed[i])
        begin
            if (directed[i].kind == STEP_CFG)
            begin
                wait_idle();
                write_reg(directed[i].reg_idx, directed[i].reg_val);
            end
            else
            begin
                // Arm the fixed expectation after the previous transfer is recorded
                @(negedge clk);
                s_tvalid  = 1'b0;
                pin_armed = directed[i].pinned;
                pin_want  = directed[i].want;
                send_item(directed[i].act, directed[i].data);
            end
        end

        // Random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            pin_armed = 1'b0;
            set_layout_regs(phase);
            n = 0;
            while (n < RANDOM_ITEMS / PHASES)
            begin
                if (n % 32 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                // Now and then hold off until the result side is empty
                if ($urandom_range(0, 59) == 0)
                    wait_idle();
                d    = 48'({$urandom, $urandom});
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    act    = ACT_PIXEL;
                    x_span = 16 << eff_width_log2();
                    y_span = 16 << eff_height_log2();
                    if ($urandom_range(0, 6) != 0)
                        d[7:0] = 8'($urandom_range(0, x_span - 1));
                    if ($urandom_range(0, 6) != 0)
                        d[15:8] = 8'($urandom_range(0, y_span - 1));
                    d[23:16] = 8'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255));
                end
                else if (pick < 88)
                begin
                    act = ACT_CHAR;
                    if ($urandom_range(0, 7) == 0)
                        d[31:24] = SPACE_CODE;
                end
                else if (pick < 95)
                    act = ACT_PEN;
                else
                    act = ACT_NONE;
                send_item(act, d);
                if (act != ACT_NONE)
                    n++;
            end
        end

        // Drain and let the pipeline settle
        burst = 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_glyphs.size() != 0)
            report_mismatch("expected glyphs left over at the end");
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/gwml_pkg.sv
src/gwml_cell_decode.sv
src/gwml_ink_table.sv
src/glyph_width_measure_and_layout.sv
sim/glyph_width_measure_and_layout_tb.sv
